// ===== sv/channel_message_queue_engine_assert.svh =====
// assertion macros for the channel message queue engine
`ifndef CHANNEL_MESSAGE_QUEUE_ENGINE_ASSERT_SVH
`define CHANNEL_MESSAGE_QUEUE_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CMQE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CMQE_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CMQE_ASSERT(lbl, clk, rst_n, prop)
`define CMQE_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== sv/cmqe_pkg.sv =====
// shared types and codes for the channel message queue engine
`timescale 1ns / 1ps
package cmqe_pkg;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_SEND    = 2'd2,
    OP_RECV    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_CHAN = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_BAD_LEN = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] channel;
    logic [63:0] data_word;
    logic        last;
    logic [8:0]  length;
  } cmd_t;

endpackage

// ===== sv/cmqe_front.sv =====
// front end: accepts transactions, decodes them and queues them for the back end
`timescale 1ns / 1ps
module cmqe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    op_i,
  input  logic [31:0]   channel_i,
  input  logic [63:0]   data_word_i,
  input  logic          last_i,
  input  logic [8:0]    length_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output cmqe_pkg::cmd_t cmd_o
);
  import cmqe_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_in;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    cmd_in.op        = op_e'(op_i);
    cmd_in.channel   = channel_i;
    cmd_in.data_word = data_word_i;
    cmd_in.last      = last_i;
    cmd_in.length    = length_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/cmqe_back.sv =====
// back end: slot table, message memories and the sequencer that runs each command
`timescale 1ns / 1ps
`include "channel_message_queue_engine_assert.svh"
module cmqe_back #(
  parameter int NUM_QUEUES        = 16,
  parameter int QUEUE_DEPTH       = 64,
  parameter int MAX_PAYLOAD_BYTES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  cmqe_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     status_o,
  output logic [3:0]     queue_index_o,
  output logic [63:0]    data_word_res_o,
  output logic [8:0]     byte_count_o,
  output logic           last_res_o
);
  import cmqe_pkg::*;

  localparam int MAX_WORDS = (MAX_PAYLOAD_BYTES + 7) / 8;
  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int DW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int MWW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int NWW = $clog2(MAX_WORDS + 1);
  localparam int PAW = QW + DW + MWW;
  localparam int LAW = QW + DW;
  localparam logic [8:0]    LEN_MAX = 9'(MAX_PAYLOAD_BYTES);
  localparam logic [NWW-1:0] NW_MAX = NWW'(MAX_WORDS);
  localparam logic [CW-1:0] CNT_MAX = CW'(QUEUE_DEPTH);
  localparam logic [DW-1:0] PTR_LAST = DW'(QUEUE_DEPTH - 1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_FIND     = 8'b0000_0010,
    S_EXEC     = 8'b0000_0100,
    S_RLEN     = 8'b0000_1000,
    S_COPY_RD  = 8'b0001_0000,
    S_COPY_WR  = 8'b0010_0000,
    S_RECV_RD  = 8'b0100_0000,
    S_RECV_OUT = 8'b1000_0000
  } state_e;
  // single-result response is folded into the exec/rlen/copy paths through resp_pend_q

  state_e state_q, state_d;

  // slot table
  logic          active_q [NUM_QUEUES];
  logic [31:0]   chan_q   [NUM_QUEUES];
  logic [DW-1:0] rp_q     [NUM_QUEUES];
  logic [DW-1:0] wp_q     [NUM_QUEUES];
  logic [CW-1:0] cnt_q    [NUM_QUEUES];

  // memories
  logic [63:0] stage_mem [MAX_WORDS];
  logic [63:0] pay_mem   [2**PAW];
  logic [8:0]  len_mem   [2**LAW];
  logic [63:0] stage_rd_q, pay_rd_q;
  logic [8:0]  len_rd_q;

  cmd_t           cur_q;
  logic [NWW-1:0] wsf_q, nstage_q, nw_q, w_q;
  logic           overrun_q;
  logic           hit_q, free_hit_q;
  logic [QW-1:0]  idx_q, free_idx_q;
  logic [DW-1:0]  slot_q;
  logic [8:0]     copy_q;
  logic           resp_pend_q;
  status_e        resp_st_q;
  logic [3:0]     resp_idx_q;

  logic           out_valid_q;
  logic [2:0]     out_st_q;
  logic [3:0]     out_idx_q;
  logic [63:0]    out_data_q;
  logic [8:0]     out_bc_q;
  logic           out_last_q;
  logic           out_free;

  logic          match_hit, free_hit;
  logic [QW-1:0] match_idx, free_idx;
  logic          pop;
  logic [9:0]    len_up;
  logic [8:0]    copy_c, rem;
  logic [63:0]   masked;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE) && !resp_pend_q;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // first active match and first free slot
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (active_q[i] && chan_q[i] == cur_q.channel) begin
        match_hit = 1'b1;
        match_idx = QW'(i);
      end
      if (!active_q[i]) begin
        free_hit = 1'b1;
        free_idx = QW'(i);
      end
    end
  end

  assign len_up = {1'b0, cur_q.length} + 10'd7;
  assign copy_c = (len_rd_q < cur_q.length) ? len_rd_q : cur_q.length;
  assign rem    = copy_q - 9'({w_q, 3'b000});

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      masked[8*b +: 8] = (rem > 9'(b)) ? pay_rd_q[8*b +: 8] : 8'h00;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.op == OP_SEND && wsf_q < NW_MAX) begin
      stage_mem[wsf_q[MWW-1:0]] <= cmd_i.data_word;
    end
    if (state_q == S_COPY_RD) begin
      stage_rd_q <= stage_mem[w_q[MWW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_COPY_WR) begin
      pay_mem[{idx_q, slot_q, w_q[MWW-1:0]}] <= (w_q < nstage_q) ? stage_rd_q : 64'd0;
    end
    if (state_q == S_RECV_RD) begin
      pay_rd_q <= pay_mem[{idx_q, slot_q, w_q[MWW-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && cur_q.op == OP_SEND && hit_q && !overrun_q &&
        cur_q.length <= LEN_MAX && cnt_q[idx_q] < CNT_MAX) begin
      len_mem[{idx_q, wp_q[idx_q]}] <= cur_q.length;
    end
    if (state_q == S_EXEC) begin
      len_rd_q <= len_mem[{idx_q, rp_q[idx_q]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && cur_q.op == OP_CREATE && free_hit_q) begin
      chan_q[free_idx_q] <= cur_q.channel;
    end
  end

  // payload-side registers
  always_ff @(posedge clk_i) begin
    if (pop) cur_q <= cmd_i;
    if (state_q == S_FIND) begin
      hit_q      <= match_hit;
      idx_q      <= match_idx;
      free_hit_q <= free_hit;
      free_idx_q <= free_idx;
    end
    if (state_q == S_EXEC) begin
      nstage_q <= wsf_q;
      nw_q     <= NWW'(len_up >> 3);
      slot_q   <= (cur_q.op == OP_SEND) ? wp_q[idx_q] : rp_q[idx_q];
    end
    if (state_q == S_RLEN) begin
      copy_q <= (copy_c > LEN_MAX) ? LEN_MAX : copy_c;
      nw_q   <= NWW'((({1'b0, ((copy_c > LEN_MAX) ? LEN_MAX : copy_c)}) + 10'd7) >> 3);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (pop && (cmd_i.op != OP_SEND || cmd_i.last)) state_d = S_FIND;
      S_FIND:     state_d = S_EXEC;
      S_EXEC: begin
        if (cur_q.op == OP_RECV && hit_q && cnt_q[idx_q] != '0) begin
          state_d = S_RLEN;
        end else if (cur_q.op == OP_SEND && hit_q && !overrun_q &&
                     cur_q.length <= LEN_MAX && cnt_q[idx_q] < CNT_MAX &&
                     len_up[9:3] != 7'd0) begin
          state_d = S_COPY_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RLEN:     state_d = (copy_c == 9'd0) ? S_IDLE : S_RECV_RD;
      S_COPY_RD:  state_d = S_COPY_WR;
      S_COPY_WR:  state_d = (w_q + NWW'(1) == nw_q) ? S_IDLE : S_COPY_RD;
      S_RECV_RD:  state_d = S_RECV_OUT;
      S_RECV_OUT: begin
        if (out_free) state_d = (w_q + NWW'(1) == nw_q) ? S_IDLE : S_RECV_RD;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wsf_q       <= '0;
      overrun_q   <= 1'b0;
      w_q         <= '0;
      resp_pend_q <= 1'b0;
      resp_st_q   <= ST_OK;
      resp_idx_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        active_q[i] <= 1'b0;
        rp_q[i]     <= '0;
        wp_q[i]     <= '0;
        cnt_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      // staging of send words
      if (pop && cmd_i.op == OP_SEND) begin
        if (wsf_q < NW_MAX) wsf_q <= wsf_q + NWW'(1);
        else overrun_q <= 1'b1;
      end

      if (state_q == S_EXEC) begin
        resp_idx_q <= '0;
        resp_st_q  <= ST_OK;
        priority case (cur_q.op)
          OP_CREATE: begin
            if (free_hit_q) begin
              active_q[free_idx_q] <= 1'b1;
              rp_q[free_idx_q]     <= '0;
              wp_q[free_idx_q]     <= '0;
              cnt_q[free_idx_q]    <= '0;
              resp_idx_q           <= 4'(free_idx_q);
            end else begin
              resp_st_q <= ST_NO_SPACE;
            end
            resp_pend_q <= 1'b1;
          end
          OP_DESTROY: begin
            if (hit_q) active_q[idx_q] <= 1'b0;
            else resp_st_q <= ST_NO_CHAN;
            resp_pend_q <= 1'b1;
          end
          OP_SEND: begin
            if (cur_q.length > LEN_MAX || overrun_q) begin
              resp_st_q <= ST_BAD_LEN;
              resp_pend_q <= 1'b1;
            end else if (!hit_q) begin
              resp_st_q <= ST_NO_CHAN;
              resp_pend_q <= 1'b1;
            end else if (cnt_q[idx_q] >= CNT_MAX) begin
              resp_st_q <= ST_NO_SPACE;
              resp_pend_q <= 1'b1;
            end else begin
              wp_q[idx_q]  <= (wp_q[idx_q] == PTR_LAST) ? '0 : wp_q[idx_q] + DW'(1);
              cnt_q[idx_q] <= cnt_q[idx_q] + CW'(1);
              w_q <= '0;
              if (len_up[9:3] == 7'd0) resp_pend_q <= 1'b1;
            end
            wsf_q     <= '0;
            overrun_q <= 1'b0;
          end
          OP_RECV: begin
            if (!hit_q) begin
              resp_st_q <= ST_NO_CHAN;
              resp_pend_q <= 1'b1;
            end else if (cnt_q[idx_q] == '0) begin
              resp_st_q <= ST_EMPTY;
              resp_pend_q <= 1'b1;
            end else begin
              rp_q[idx_q]  <= (rp_q[idx_q] == PTR_LAST) ? '0 : rp_q[idx_q] + DW'(1);
              cnt_q[idx_q] <= cnt_q[idx_q] - CW'(1);
              w_q <= '0;
            end
          end
          default: resp_pend_q <= 1'b1;
        endcase
      end

      if (state_q == S_RLEN && copy_c == 9'd0) begin
        resp_st_q   <= ST_OK;
        resp_idx_q  <= '0;
        resp_pend_q <= 1'b1;
      end

      if (state_q == S_COPY_WR) begin
        w_q <= w_q + NWW'(1);
        if (w_q + NWW'(1) == nw_q) begin
          resp_st_q   <= ST_OK;
          resp_idx_q  <= '0;
          resp_pend_q <= 1'b1;
        end
      end

      if (state_q == S_RECV_OUT && out_free) begin
        out_valid_q <= 1'b1;
        out_st_q    <= ST_OK;
        out_idx_q   <= '0;
        out_data_q  <= masked;
        out_bc_q    <= copy_q;
        out_last_q  <= (w_q + NWW'(1) == nw_q);
        w_q         <= w_q + NWW'(1);
      end

      if (resp_pend_q && state_q == S_IDLE && out_free) begin
        out_valid_q <= 1'b1;
        out_st_q    <= resp_st_q;
        out_idx_q   <= resp_idx_q;
        out_data_q  <= '0;
        out_bc_q    <= '0;
        out_last_q  <= 1'b1;
        resp_pend_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign queue_index_o   = out_idx_q;
  assign data_word_res_o = out_data_q;
  assign byte_count_o    = out_bc_q;
  assign last_res_o      = out_last_q;

  `CMQE_ASSERT(a_cnt_bound, clk_i, rst_ni, (state_q == S_EXEC) |-> (cnt_q[idx_q] <= CNT_MAX))
  `CMQE_ASSERT(a_stage_bound, clk_i, rst_ni, wsf_q <= NW_MAX)
  `CMQE_ASSERT(a_copy_word, clk_i, rst_ni, (state_q == S_COPY_WR) |-> (w_q < nw_q))
  `CMQE_NEVER(a_no_pop_busy, clk_i, rst_ni, pop && resp_pend_q)
endmodule

// ===== sv/channel_message_queue_engine.sv =====
// top level of the channel message queue engine
//
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i/in_ready_o   | op, channel, data_word, last, length
//  out     | source    | out_valid_o/out_ready_i | status, queue_index, data_word_res,
//          |           |                         | byte_count, last_res
//
// sequencing: a send word that is not last is only staged; create and destroy pass through
//   find and exec; a send commit copies each stored word and a receive returns each word,
//   paced by the single-port payload memory and the staging read before each write
// reset: slot table and staging count clear at once; message memories need no clearing
// stalls: a two-entry command queue lets the front take transactions while the back works;
//   the output register holds a result until taken and the back waits on it
`timescale 1ns / 1ps
module channel_message_queue_engine #(
  parameter int NUM_QUEUES        = 16,
  parameter int QUEUE_DEPTH       = 64,
  parameter int MAX_PAYLOAD_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] channel_i,
  input  logic [63:0] data_word_i,
  input  logic        last_i,
  input  logic [8:0]  length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  queue_index_o,
  output logic [63:0] data_word_res_o,
  output logic [8:0]  byte_count_o,
  output logic        last_res_o
);
  import cmqe_pkg::*;

  // decoded commands between front and back
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  cmqe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .channel_i   (channel_i),
    .data_word_i (data_word_i),
    .last_i      (last_i),
    .length_i    (length_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // slot table, memories and sequencer
  cmqe_back #(
    .NUM_QUEUES        (NUM_QUEUES),
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .queue_index_o   (queue_index_o),
    .data_word_res_o (data_word_res_o),
    .byte_count_o    (byte_count_o),
    .last_res_o      (last_res_o)
  );

endmodule
